// File: sv/gusd_pkg.sv
// Shared types, register indexes and defaults for the grid unknown square detector.
package gusd_pkg;

  localparam int MAX_X_CELLS_DEF = 256;
  localparam int MAX_Y_CELLS_DEF = 256;
  localparam int MAX_SQUARE_DEF  = 16;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [8:0] GRID_WIDTH_RST   = 9'd256;
  localparam logic [8:0] GRID_HEIGHT_RST  = 9'd256;
  localparam logic [4:0] MIN_SQUARE_RST   = 5'd1;
  localparam logic [7:0] UNKNOWN_CODE_RST = 8'd50;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_MIN_SQUARE,
    REG_UNKNOWN_CODE
  } reg_idx_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] cell_value;
  } in_req_t;

  typedef struct packed {
    logic       is_spot;
    logic [7:0] spot_x;
    logic [7:0] spot_y;
  } out_res_t;

  typedef struct packed {
    logic load;
    logic write;
    logic prep;
    logic init;
    logic issue;
    logic finish;
    logic pass;
  } gusd_cmd_t;

  typedef struct packed {
    logic reject;
    logic last;
    logic fail;
    logic empty;
  } gusd_stat_t;

endpackage

// File: sv/grid_unknown_square_detector_unit.sv
// Top level of the grid unknown square detector: config registers, controller, datapath.
//
//  channel   ports                               handshake
//  input     start, busy, in_req                 taken when start && !busy
//  result    out_valid, out_res                  one-cycle strobe, no back-pressure
//  config    psel, penable, pwrite, paddr,       APB write on psel&penable&pwrite,
//            pwdata, prdata, pready              pready tied high
//
// A write request passes through the write state. A query ends after the centre check
// when that rejects, else it scans all N window cells, at most (2*MAX_SQUARE-1)^2; the single
// read port of the grid memory sets one cell per cycle. Once the known-cell count exceeds
// the limit during the scan, the query ends early, without issuing the remaining cells.
// Reset clears control state and the config registers only; grid contents
// stay undefined until written, no clearing pass.
// The result strobe cannot be stalled; the next request may be taken in the same cycle.
module grid_unknown_square_detector_unit import gusd_pkg::*; #(
  parameter int MAX_X_CELLS = MAX_X_CELLS_DEF,
  parameter int MAX_Y_CELLS = MAX_Y_CELLS_DEF,
  parameter int MAX_SQUARE  = MAX_SQUARE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_req,
  output logic              out_valid,
  output out_res_t          out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [8:0] grid_width_r;
  logic [8:0] grid_height_r;
  logic [4:0] min_square_r;
  logic [7:0] unknown_code_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  gusd_cmd_t  cmd;
  gusd_stat_t stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= GRID_WIDTH_RST;
      grid_height_r  <= GRID_HEIGHT_RST;
      min_square_r   <= MIN_SQUARE_RST;
      unknown_code_r <= UNKNOWN_CODE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GRID_WIDTH:   grid_width_r   <= pwdata[8:0];
        REG_GRID_HEIGHT:  grid_height_r  <= pwdata[8:0];
        REG_MIN_SQUARE:   min_square_r   <= pwdata[4:0];
        REG_UNKNOWN_CODE: unknown_code_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GRID_WIDTH:   prdata = CFG_DW'(grid_width_r);
      REG_GRID_HEIGHT:  prdata = CFG_DW'(grid_height_r);
      REG_MIN_SQUARE:   prdata = CFG_DW'(min_square_r);
      REG_UNKNOWN_CODE: prdata = CFG_DW'(unknown_code_r);
      default:          prdata = '0;
    endcase
  end

  gusd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .req_op (in_req.operation),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  gusd_dp #(
    .MAX_X_CELLS (MAX_X_CELLS),
    .MAX_Y_CELLS (MAX_Y_CELLS),
    .MAX_SQUARE  (MAX_SQUARE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (in_req),
    .cmd          (cmd),
    .stat         (stat),
    .grid_width   (grid_width_r),
    .grid_height  (grid_height_r),
    .min_square   (min_square_r),
    .unknown_code (unknown_code_r),
    .out_valid    (out_valid),
    .out_res      (out_res)
  );

endmodule

// File: sv/gusd_ctrl.sv
// Controller state machine sequencing writes, centre check and window scan.
module gusd_ctrl import gusd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       req_op,
  input  gusd_stat_t stat,
  output gusd_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SETUP,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (req_op == OP_WRITE) ? ST_WRITE : ST_SETUP;
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_SETUP: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = stat.reject ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (stat.fail) begin
          state_nxt = ST_IDLE;
        end else if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.fail || stat.empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == ST_IDLE) && start;
    cmd.write  = (state_r == ST_WRITE);
    cmd.prep   = (state_r == ST_SETUP);
    cmd.init   = (state_r == ST_CHECK) && !stat.reject;
    cmd.issue  = (state_r == ST_SCAN) && !stat.fail;
    cmd.pass   = (state_r == ST_DRAIN) && !stat.fail && stat.empty;
    cmd.finish = ((state_r == ST_CHECK) && stat.reject) ||
                 ((state_r == ST_SCAN) && stat.fail) ||
                 ((state_r == ST_DRAIN) && (stat.fail || stat.empty));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// File: sv/gusd_dp.sv
// Datapath: grid memory, window bounds, scan counters, count and result register.
module gusd_dp import gusd_pkg::*; #(
  parameter int MAX_X_CELLS = MAX_X_CELLS_DEF,
  parameter int MAX_Y_CELLS = MAX_Y_CELLS_DEF,
  parameter int MAX_SQUARE  = MAX_SQUARE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_req_t    in_req,
  input  gusd_cmd_t  cmd,
  output gusd_stat_t stat,
  input  logic [8:0] grid_width,
  input  logic [8:0] grid_height,
  input  logic [4:0] min_square,
  input  logic [7:0] unknown_code,
  output logic       out_valid,
  output out_res_t   out_res
);

  localparam int XW    = $clog2(MAX_X_CELLS);
  localparam int YW    = $clog2(MAX_Y_CELLS);
  localparam int DEPTH = MAX_X_CELLS * MAX_Y_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SQUARE + 1);
  localparam int CNTW  = SW + 1;
  localparam int MW1   = (XW > YW) ? XW : YW;
  localparam int MW2   = (MW1 > SW) ? MW1 : SW;
  localparam int MW    = (MW2 > 8) ? MW2 : 8;
  localparam int FW    = MW + 3;
  localparam int CWX   = ($clog2(MAX_X_CELLS + 1) > 9) ? $clog2(MAX_X_CELLS + 1) : 9;
  localparam int CWY   = ($clog2(MAX_Y_CELLS + 1) > 9) ? $clog2(MAX_Y_CELLS + 1) : 9;

  function automatic logic [2*FW-1:0] fit_win(logic signed [FW-1:0] c,
                                              logic signed [FW-1:0] h,
                                              logic signed [FW-1:0] top);
    logic signed [FW-1:0] a, b, h2, t2, lo, hi;
    a  = c - h;
    b  = c + h;
    h2 = h + h;
    t2 = top - h2;
    if (a[FW-1]) begin
      lo = '0;
      hi = (h2 > top) ? top : h2;
    end else if (b > top) begin
      lo = t2[FW-1] ? '0 : t2;
      hi = top;
    end else begin
      lo = a;
      hi = b;
    end
    return {lo, hi};
  endfunction

  in_req_t              req_r;
  logic                 wr_ok_r;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [7:0]           mem_r [0:DEPTH-1];
  logic [7:0]           rd_data_r;
  logic [XW-1:0]        lo_x_r, hi_x_r, sx_r;
  logic [YW-1:0]        lo_y_r, hi_y_r, sy_r;
  logic [CNTW-1:0]      sz1_r, count_r, count_nxt;
  logic                 skip_r;
  logic                 v1_r, v2_r;
  logic                 out_valid_r;
  out_res_t             out_res_r;

  logic [XW-1:0]        top_x, ax;
  logic [YW-1:0]        top_y, ay;
  logic [SW-1:0]        sz, half;
  logic signed [FW-1:0] cx_s, cy_s, half_s, topx_s, topy_s;
  logic [2*FW-1:0]      fit_x, fit_y;
  logic                 outside, fail;

  always_comb begin
    if (grid_width == 9'd0) begin
      top_x = '0;
    end else if (CWX'(grid_width) > CWX'(MAX_X_CELLS)) begin
      top_x = XW'(MAX_X_CELLS - 1);
    end else begin
      top_x = XW'(grid_width - 9'd1);
    end
    if (grid_height == 9'd0) begin
      top_y = '0;
    end else if (CWY'(grid_height) > CWY'(MAX_Y_CELLS)) begin
      top_y = YW'(MAX_Y_CELLS - 1);
    end else begin
      top_y = YW'(grid_height - 9'd1);
    end
    if (32'(min_square) > MAX_SQUARE) begin
      sz = SW'(MAX_SQUARE);
    end else begin
      sz = SW'(min_square);
    end
    half = (sz == SW'(1)) ? SW'(1) : SW'(sz - SW'(1));
  end

  assign cx_s    = signed'(FW'(req_r.cell_x));
  assign cy_s    = signed'(FW'(req_r.cell_y));
  assign half_s  = signed'(FW'(half));
  assign topx_s  = signed'(FW'(top_x));
  assign topy_s  = signed'(FW'(top_y));
  assign fit_x   = fit_win(cx_s, half_s, topx_s);
  assign fit_y   = fit_win(cy_s, half_s, topy_s);
  assign outside = (FW'(req_r.cell_x) > FW'(top_x)) || (FW'(req_r.cell_y) > FW'(top_y));

  assign ax       = cmd.load ? XW'(in_req.cell_x) : sx_r;
  assign ay       = cmd.load ? YW'(in_req.cell_y) : sy_r;
  assign addr_nxt = AW'(AW'(ay) * AW'(MAX_X_CELLS)) + AW'(ax);

  assign fail = (count_r > sz1_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.init) begin
      count_nxt = '0;
    end else if (v2_r && (rd_data_r != unknown_code) && !fail) begin
      count_nxt = CNTW'(count_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok_r) begin
      mem_r[addr_r] <= req_r.cell_value;
    end
    rd_data_r <= mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      wr_ok_r <= (32'(in_req.cell_x) < MAX_X_CELLS) && (32'(in_req.cell_y) < MAX_Y_CELLS);
    end
    if (cmd.load || cmd.issue) begin
      addr_r <= addr_nxt;
    end
    if (cmd.prep) begin
      lo_x_r <= XW'(fit_x[2*FW-1:FW]);
      hi_x_r <= XW'(fit_x[FW-1:0]);
      lo_y_r <= YW'(fit_y[2*FW-1:FW]);
      hi_y_r <= YW'(fit_y[FW-1:0]);
      sz1_r  <= CNTW'(CNTW'(sz) + 1'b1);
      skip_r <= (sz == '0) || outside;
    end
    if (cmd.init) begin
      sx_r <= lo_x_r;
      sy_r <= lo_y_r;
    end else if (cmd.issue) begin
      if (sy_r == hi_y_r) begin
        sy_r <= lo_y_r;
        sx_r <= XW'(sx_r + 1'b1);
      end else begin
        sy_r <= YW'(sy_r + 1'b1);
      end
    end
    count_r <= count_nxt;
    if (cmd.finish) begin
      out_res_r.is_spot <= cmd.pass;
      out_res_r.spot_x  <= req_r.cell_x;
      out_res_r.spot_y  <= req_r.cell_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= cmd.finish;
    end
  end

  assign stat.reject = skip_r || (rd_data_r != unknown_code);
  assign stat.last   = (sx_r == hi_x_r) && (sy_r == hi_y_r);
  assign stat.fail   = fail;
  assign stat.empty  = !v1_r && !v2_r;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: sv/gusd_chk.sv
// Port-level checker for the grid unknown square detector, bound to the top level.
module gusd_chk import gusd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_req_t  in_req,
  input logic     out_valid
);

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while block still busy");

  a_request_takes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_write_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == OP_WRITE) |=>
      (busy && !out_valid) ##1 (!busy && !out_valid))
    else $error("write request timing or spurious result");

  a_query_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == OP_QUERY) |=> !out_valid ##1 !out_valid)
    else $error("query result too early");

endmodule

bind grid_unknown_square_detector_unit gusd_chk u_gusd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid)
);

// File: dv/grid_unknown_square_detector_unit_tb.sv
// Self-checking testbench for the grid unknown square detector: requests, APB setup, checks.
module grid_unknown_square_detector_unit_tb;
  import gusd_pkg::*;

  localparam int GRID_SPAN     = 256;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_req_t           in_req  = '0;
  logic              out_valid;
  out_res_t          out_res;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  grid_unknown_square_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  logic [8:0] grid_w  = GRID_WIDTH_RST;
  logic [8:0] grid_h  = GRID_HEIGHT_RST;
  logic [4:0] square  = MIN_SQUARE_RST;
  logic [7:0] unk     = UNKNOWN_CODE_RST;

  logic [7:0] cell_code    [0:GRID_SPAN*GRID_SPAN-1];
  logic [7:0] planned_code [0:GRID_SPAN*GRID_SPAN-1];
  bit         planned_set  [0:GRID_SPAN*GRID_SPAN-1];

  in_req_t  request_q     [$];
  out_res_t spot_answers  [$];

  int idle_pct      = 0;
  int phase_items   = 0;
  int phase_queries = 0;
  int mismatches    = 0;
  int writes_done   = 0;
  int queries_done  = 0;
  int answers_seen  = 0;
  int spots_seen    = 0;

  int unsigned phase_cfg [7][4] = '{
    '{256, 256,  2,   0},
    '{ 16,  12,  3, 255},
    '{  1,   1, 16,   7},
    '{  0, 300, 31, 200},
    '{  5,   9,  0, 128},
    '{511,  20,  3,  50},
    '{  2,  31, 16,   1}
  };

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int dim_in_use(logic [8:0] v);
    if (v == 0) return 1;
    if (v > GRID_SPAN) return GRID_SPAN;
    return int'(v);
  endfunction

  function automatic int square_in_use();
    return (square > MAX_SQUARE_DEF) ? MAX_SQUARE_DEF : int'(square);
  endfunction

  // shift the window back inside [0,top], then clip it
  function automatic void fit_span(input int centre, input int top, output int lo, output int hi);
    int a, b, half;
    half = (square_in_use() == 1) ? 1 : square_in_use() - 1;
    a = centre - half;
    b = centre + half;
    if (a < 0) b += -a;
    if (b > top) a -= b - top;
    if (a < 0) a = 0;
    if (b > top) b = top;
    lo = a;
    hi = b;
  endfunction

  function automatic bit judge_square(int cx, int cy);
    int w, h, sz, x0, x1, y0, y1, x, y, known;
    w = dim_in_use(grid_w);
    h = dim_in_use(grid_h);
    sz = square_in_use();
    known = 0;
    if (sz == 0 || cx >= w || cy >= h) return 1'b0;
    if (cell_code[cy*GRID_SPAN+cx] != unk) return 1'b0;
    fit_span(cx, w - 1, x0, x1);
    fit_span(cy, h - 1, y0, y1);
    for (x = x0; x <= x1; x++) begin
      for (y = y0; y <= y1; y++) begin
        if (cell_code[y*GRID_SPAN+x] != unk) known++;
      end
    end
    return known <= sz + 1;
  endfunction

  function automatic void queue_request(logic op, int x, int y, logic [7:0] v);
    in_req_t r;
    r.operation  = op;
    r.cell_x     = x[7:0];
    r.cell_y     = y[7:0];
    r.cell_value = v;
    if (op == OP_WRITE) begin
      planned_code[y*GRID_SPAN+x] = v;
      planned_set[y*GRID_SPAN+x]  = 1'b1;
    end else begin
      phase_queries++;
    end
    request_q.insert(request_q.size(), r);
    phase_items++;
  endfunction

  function automatic logic [7:0] known_code();
    return unk + 8'(1 + $urandom_range(254));
  endfunction

  function automatic void fill_cell(int x, int y, int known_pct);
    if (!planned_set[y*GRID_SPAN+x])
      queue_request(OP_WRITE, x, y, ($urandom_range(99) < known_pct) ? known_code() : unk);
  endfunction

  // write every cell the query will read that holds nothing yet, then query
  function automatic void plan_query(int cx, int cy, int known_pct);
    int w, h, x0, x1, y0, y1, x, y;
    w = dim_in_use(grid_w);
    h = dim_in_use(grid_h);
    fill_cell(cx, cy, 30);
    if (square_in_use() != 0 && cx < w && cy < h && planned_code[cy*GRID_SPAN+cx] == unk) begin
      fit_span(cx, w - 1, x0, x1);
      fit_span(cy, h - 1, y0, y1);
      for (x = x0; x <= x1; x++) begin
        for (y = y0; y <= y1; y++) fill_cell(x, y, known_pct);
      end
    end
    queue_request(OP_QUERY, cx, cy, 8'($urandom));
  endfunction

  function automatic int pick_coord(int dim);
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return dim - 1;
    if (r < 35) return $urandom_range(GRID_SPAN - 1);
    return $urandom_range(dim - 1);
  endfunction

  function automatic void random_traffic();
    int w, h, pct;
    w = dim_in_use(grid_w);
    h = dim_in_use(grid_h);
    phase_items = 0;
    phase_queries = 0;
    while (phase_items < 30 || phase_queries < 3) begin
      if ($urandom_range(9) < 2) begin
        queue_request(OP_WRITE, pick_coord(w), pick_coord(h),
                      $urandom_range(1) ? unk : 8'($urandom));
      end else begin
        case ($urandom_range(5))
          0: pct = 0;
          1: pct = 3;
          2: pct = 8;
          3: pct = 15;
          4: pct = 40;
          default: pct = 100;
        endcase
        plan_query(pick_coord(w), pick_coord(h), pct);
      end
    end
  endfunction

  task automatic write_register(reg_idx_t idx, int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:   grid_w = value[8:0];
      REG_GRID_HEIGHT:  grid_h = value[8:0];
      REG_MIN_SQUARE:   square = value[4:0];
      REG_UNKNOWN_CODE: unk    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || start || spot_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // request driver and predictor
  always @(posedge clk) begin : drive_requests
    out_res_t answer;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (in_req.operation == OP_WRITE) begin
          cell_code[int'(in_req.cell_y)*GRID_SPAN+int'(in_req.cell_x)] = in_req.cell_value;
          writes_done++;
        end else begin
          answer.is_spot = judge_square(int'(in_req.cell_x), int'(in_req.cell_y));
          answer.spot_x  = in_req.cell_x;
          answer.spot_y  = in_req.cell_y;
          spot_answers.insert(spot_answers.size(), answer);
          queries_done++;
        end
      end
      if (!start || !busy) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start  <= 1'b1;
          in_req <= request_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_mismatch(string what, out_res_t exp, out_res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch (%s): expected spot=%0b x=%0d y=%0d, got spot=%0b x=%0d y=%0d",
               what, exp.is_spot, exp.spot_x, exp.spot_y, got.is_spot, got.spot_x, got.spot_y);
  endfunction

  // answer monitor
  always @(posedge clk) begin : check_answers
    out_res_t exp;
    if (rst_n && out_valid) begin
      answers_seen++;
      if (out_res.is_spot === 1'b1) spots_seen++;
      if (spot_answers.size() == 0) begin
        flag_mismatch("no query waiting", '0, out_res);
      end else begin
        exp = spot_answers.pop_front();
        if (out_res.is_spot !== exp.is_spot || out_res.spot_x !== exp.spot_x ||
            out_res.spot_y !== exp.spot_y)
          flag_mismatch("answer", exp, out_res);
      end
    end
  end

  initial begin
    #(8 * 3_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // corners, field extremes, known-count threshold, rejected centre
    queue_request(OP_WRITE, 0, 0, unk);
    plan_query(0, 0, 0);
    queue_request(OP_WRITE, 1, 1, 8'hFF);
    queue_request(OP_WRITE, 2, 0, 8'h00);
    plan_query(0, 0, 0);
    queue_request(OP_WRITE, 0, 2, 8'h80);
    plan_query(0, 0, 0);
    queue_request(OP_WRITE, 255, 255, 8'hFF);
    plan_query(255, 255, 0);
    queue_request(OP_WRITE, 255, 0, unk);
    plan_query(255, 0, 100);
    wait_idle();
    random_traffic();
    wait_idle();

    for (p = 0; p < 7; p++) begin
      case ((p + 1) % 4)
        1:       idle_pct = 57;
        3:       idle_pct = 38;
        default: idle_pct = 0;
      endcase
      write_register(REG_GRID_WIDTH,   phase_cfg[p][0]);
      write_register(REG_GRID_HEIGHT,  phase_cfg[p][1]);
      write_register(REG_MIN_SQUARE,   phase_cfg[p][2]);
      write_register(REG_UNKNOWN_CODE, phase_cfg[p][3]);
      random_traffic();
      wait_idle();
    end

    $display("covered %0d cell writes and %0d queries over 8 register settings",
             writes_done, queries_done);
    $display("%0d answers checked, %0d of them spots, %0d mismatches",
             answers_seen, spots_seen, mismatches);
    if (mismatches == 0 && spot_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/gusd_pkg.sv
sv/gusd_ctrl.sv
sv/gusd_dp.sv
sv/grid_unknown_square_detector_unit.sv
sv/gusd_chk.sv
dv/grid_unknown_square_detector_unit_tb.sv
